### design/rational_add_sub_normalize_core_defines.svh
// Assertion macros shared by the rational add/subtract core.
// Define NO_ASSERTIONS to compile the design without checks.
`ifndef RATIONAL_ADD_SUB_NORMALIZE_CORE_DEFINES_SVH
`define RATIONAL_ADD_SUB_NORMALIZE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RAS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RAS_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAS_ASSERT(lbl, clk, rst, prop, msg)
`define RAS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### design/ras_pkg.sv
// Shared types and constants of the rational add/subtract core.
// No dependencies.
`default_nettype none
package ras_pkg;
   localparam int NUM_W = 32;
   localparam int DEN_W = 31;
   localparam int WIDE_W = 64;
   localparam int CNT_W = 7;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_SUB = 1'b1;

   typedef struct packed {
      logic load;
      logic mul;
      logic combine;
      logic gcd_init;
      logic gcd_step;
      logic div_init;
      logic div_step;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic den_zero;
      logic num_zero;
      logic gcd_done;
      logic div_done;
   } stat_type;
endpackage
`default_nettype wire

### design/ras_datapath.sv
// Datapath: cross products, binary gcd, restoring division and range check.
// Depends on ras_pkg.
`default_nettype none
module ras_datapath (
   input  wire logic                    clock,
   input  wire ras_pkg::ctrl_type       ctrl,
   output ras_pkg::stat_type            stat,
   input  wire logic                    in_cmd,
   input  wire logic [ras_pkg::NUM_W-1:0] in_a_num,
   input  wire logic [ras_pkg::DEN_W-1:0] in_a_den,
   input  wire logic [ras_pkg::NUM_W-1:0] in_b_num,
   input  wire logic [ras_pkg::DEN_W-1:0] in_b_den,
   output logic [ras_pkg::NUM_W-1:0]    out_num,
   output logic [ras_pkg::DEN_W-1:0]    out_den,
   output logic                         out_eq,
   output logic                         out_ovf
);
   import ras_pkg::*;
   `include "rational_add_sub_normalize_core_defines.svh"

   logic                    sub_ff;
   logic signed [NUM_W-1:0] an_ff, bn_ff;
   logic [DEN_W-1:0]        ad_ff, bd_ff;
   logic                    eq_ff, eq_in;
   logic signed [WIDE_W-1:0] p_ff, q_ff;
   logic [WIDE_W-1:0]       d_ff;
   logic                    neg_ff;
   logic [WIDE_W-1:0]       mag_ff, mag_in;
   logic [WIDE_W-1:0]       x_ff, y_ff, x_in, y_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [WIDE_W-1:0]       g_ff;
   logic [WIDE_W-1:0]       qn_ff, qd_ff, rn_ff, rd_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [WIDE_W:0]         rn_sh, rd_sh;
   logic signed [WIDE_W-1:0] n_sum;
   logic [WIDE_W-1:0]       lim;
   logic                    fit;

   assign eq_in = (in_a_num == in_b_num) && (in_a_den == in_b_den);
   assign n_sum = sub_ff ? (p_ff - q_ff) : (p_ff + q_ff);
   assign mag_in = n_sum[WIDE_W-1] ? (~n_sum + 1'b1) : n_sum;

   // One binary gcd step: strip a shared two, else halve an even x or y, else subtract.
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      k_in = k_ff;
      if (!x_ff[0] && !y_ff[0]) begin
         x_in = x_ff >> 1;
         y_in = y_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!x_ff[0]) begin
         x_in = x_ff >> 1;
      end else if (!y_ff[0]) begin
         y_in = y_ff >> 1;
      end else if (x_ff > y_ff) begin
         x_in = y_ff;
         y_in = x_ff - y_ff;
      end else begin
         y_in = y_ff - x_ff;
      end
   end

   assign rn_sh = {rn_ff, qn_ff[WIDE_W-1]};
   assign rd_sh = {rd_ff, qd_ff[WIDE_W-1]};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sub_ff <= in_cmd;
         an_ff <= in_a_num;
         bn_ff <= in_b_num;
         ad_ff <= in_a_den;
         bd_ff <= in_b_den;
         eq_ff <= eq_in;
      end
      if (ctrl.mul) begin
         p_ff <= WIDE_W'(an_ff) * $signed({1'b0, bd_ff});
         q_ff <= WIDE_W'(bn_ff) * $signed({1'b0, ad_ff});
         d_ff <= WIDE_W'(ad_ff) * WIDE_W'(bd_ff);
      end
      if (ctrl.combine) begin
         neg_ff <= n_sum[WIDE_W-1];
         mag_ff <= mag_in;
      end
      // The magnitude is registered in the same cycle, so the gcd starts from mag_in.
      if (ctrl.gcd_init) begin
         x_ff <= mag_in;
         y_ff <= d_ff;
         k_ff <= '0;
      end else if (ctrl.gcd_step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         k_ff <= k_in;
      end
      if (ctrl.div_init) begin
         g_ff <= x_ff << k_ff;
         qn_ff <= mag_ff;
         qd_ff <= d_ff;
         rn_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else if (ctrl.div_step) begin
         // Restoring division of both values by g, one quotient bit a cycle.
         if (rn_sh >= {1'b0, g_ff}) begin
            rn_ff <= WIDE_W'(rn_sh - {1'b0, g_ff});
            qn_ff <= {qn_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rn_ff <= rn_sh[WIDE_W-1:0];
            qn_ff <= {qn_ff[WIDE_W-2:0], 1'b0};
         end
         if (rd_sh >= {1'b0, g_ff}) begin
            rd_ff <= WIDE_W'(rd_sh - {1'b0, g_ff});
            qd_ff <= {qd_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rd_ff <= rd_sh[WIDE_W-1:0];
            qd_ff <= {qd_ff[WIDE_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign lim = WIDE_W'(1) << (NUM_W - 1);
   assign fit = (neg_ff ? (qn_ff <= lim) : (qn_ff < lim)) && (qd_ff < lim);

   always_comb begin
      out_eq = eq_ff;
      out_num = '0;
      out_den = '0;
      out_ovf = 1'b0;
      if (stat.den_zero) begin
         out_ovf = 1'b1;
      end else if (mag_ff == '0) begin
         out_den = DEN_W'(1);
      end else if (!fit) begin
         out_ovf = 1'b1;
      end else begin
         out_num = neg_ff ? NUM_W'(~qn_ff + 1'b1) : qn_ff[NUM_W-1:0];
         out_den = qd_ff[DEN_W-1:0];
      end
   end

   assign stat.den_zero = (ad_ff == '0) || (bd_ff == '0);
   assign stat.num_zero = (mag_in == '0);
   assign stat.gcd_done = (y_ff == '0) && x_ff[0];
   assign stat.div_done = (cnt_ff == CNT_W'(WIDE_W - 1));

   `RAS_ASSERT_NR(a_gcd_odd, clock, (ctrl.gcd_step && stat.gcd_done) |-> 1'b0,
      "gcd stepped after completion")
   `RAS_ASSERT_NR(a_div_rem, clock, ctrl.div_step |=> (rn_ff < g_ff && rd_ff < g_ff),
      "division remainder not below divisor")
   `RAS_ASSERT_NR(a_init_excl, clock, !(ctrl.div_init && ctrl.gcd_step),
      "gcd and division overlap")
endmodule
`default_nettype wire

### design/ras_control.sv
// Sequencer of the rational add/subtract core: handshake and step control.
// Depends on ras_pkg.
`default_nettype none
module ras_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ras_pkg::ctrl_type      ctrl,
   input  wire ras_pkg::stat_type stat
);
   import ras_pkg::*;
   `include "rational_add_sub_normalize_core_defines.svh"

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_MUL  = 8'b0000_0010,
      S_COMB = 8'b0000_0100,
      S_GCD  = 8'b0000_1000,
      S_DIVI = 8'b0001_0000,
      S_DIV  = 8'b0010_0000,
      S_LAST = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      unique case (state_ff)
         S_IDLE: begin
            ctrl.load = req_valid;
            if (req_valid) state_in = S_MUL;
         end
         S_MUL: begin
            ctrl.mul = 1'b1;
            state_in = S_COMB;
         end
         S_COMB: begin
            ctrl.combine = 1'b1;
            ctrl.gcd_init = 1'b1;
            if (stat.den_zero) state_in = S_OUT;
            else if (stat.num_zero) state_in = S_OUT;
            else state_in = S_GCD;
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               state_in = S_DIVI;
            end else begin
               ctrl.gcd_step = 1'b1;
            end
         end
         S_DIVI: begin
            ctrl.div_init = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            ctrl.div_step = 1'b1;
            if (stat.div_done) state_in = S_OUT;
         end
         S_LAST: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            ctrl.finish = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   `RAS_ASSERT(a_no_both, clock, reset, !(rsp_valid && !req_stall),
      "input taken while result pending")
   `RAS_ASSERT(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid,
      "result dropped under stall")
   `RAS_ASSERT(a_start, clock, reset, (req_valid && !req_stall) |=> (state_ff == S_MUL),
      "accepted item did not start")
endmodule
`default_nettype wire

### design/rational_add_sub_normalize_core.sv
// Rational add/subtract with gcd reduction, top level.
// One input channel (req_), one result channel (rsp_), valid/stall handshakes.
// An item is a command and two rationals; each transfer in yields one result.
// The block works on one item at a time: it stalls req_ from acceptance until
// its result transfer completes.
// After acceptance the sequencer forms the cross products and combines them;
// a zero denominator or zero numerator goes straight to the result. Otherwise
// binary gcd steps follow (one shift or subtract per cycle), then the
// bit-serial division of numerator and denominator by the gcd.
// The result is held on rsp_ while rsp_stall is high; no new item is taken.
// Reset (synchronous, active high) returns the sequencer to idle; any item in
// flight is dropped.
// Depends on ras_pkg, ras_control and ras_datapath.
`default_nettype none
module rational_add_sub_normalize_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_cmd,
   input  wire logic [ras_pkg::NUM_W-1:0] req_a_num,
   input  wire logic [ras_pkg::DEN_W-1:0] req_a_den,
   input  wire logic [ras_pkg::NUM_W-1:0] req_b_num,
   input  wire logic [ras_pkg::DEN_W-1:0] req_b_den,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [ras_pkg::NUM_W-1:0]      rsp_res_num,
   output logic [ras_pkg::DEN_W-1:0]      rsp_res_den,
   output logic                           rsp_operands_equal,
   output logic                           rsp_overflow
);
   import ras_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   ras_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .ctrl(ctrl), .stat(stat)
   );

   ras_datapath u_datapath (
      .clock(clock), .ctrl(ctrl), .stat(stat),
      .in_cmd(req_cmd), .in_a_num(req_a_num), .in_a_den(req_a_den),
      .in_b_num(req_b_num), .in_b_den(req_b_den),
      .out_num(rsp_res_num), .out_den(rsp_res_den),
      .out_eq(rsp_operands_equal), .out_ovf(rsp_overflow)
   );
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for rational_add_sub_normalize_core.
// Predicts each sum or difference with its gcd reduction and compares the results.
// Depends on ras_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import ras_pkg::*;

   typedef struct {
      logic             cmd;
      logic [NUM_W-1:0] a_num;
      logic [DEN_W-1:0] a_den;
      logic [NUM_W-1:0] b_num;
      logic [DEN_W-1:0] b_den;
      int               gap;
      bit               drain;
   } rat_item_type;

   typedef struct {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             eq;
      logic             ovf;
   } rat_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = CMD_ADD;
   logic [NUM_W-1:0] req_a_num = '0;
   logic [DEN_W-1:0] req_a_den = '0;
   logic [NUM_W-1:0] req_b_num = '0;
   logic [DEN_W-1:0] req_b_den = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [NUM_W-1:0] rsp_res_num;
   logic [DEN_W-1:0] rsp_res_den;
   logic rsp_operands_equal;
   logic rsp_overflow;

   rat_item_type   pending_items[$];
   rat_result_type expected_sums[$];
   int  mismatch_count = 0;
   int  result_count = 0;
   int  overflow_count = 0;
   int  zero_count = 0;
   int  wait_cnt = 0;
   int  stall_cnt = 0;
   int  stall_max = 12;
   longint cycle_count = 0;

   rational_add_sub_normalize_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rat_result_type add_sub_reduce(rat_item_type it);
      rat_result_type r;
      longint an, bn, p, q, n;
      longint unsigned ad, bd, d, mag, x, y, t;
      an = longint'($signed(it.a_num));
      bn = longint'($signed(it.b_num));
      ad = longint'({33'b0, it.a_den});
      bd = longint'({33'b0, it.b_den});
      r.num = '0;
      r.den = '0;
      r.ovf = 1'b0;
      r.eq = (it.a_num == it.b_num) && (it.a_den == it.b_den);
      if (ad == 0 || bd == 0) begin
         r.ovf = 1'b1;
      end else begin
         p = an * longint'(bd);
         q = bn * longint'(ad);
         n = (it.cmd == CMD_SUB) ? p - q : p + q;
         d = ad * bd;
         if (n == 0) begin
            r.den = 1;
         end else begin
            mag = (n < 0) ? longint'(-n) : longint'(n);
            x = mag;
            y = d;
            while (y != 0) begin
               t = x % y;
               x = y;
               y = t;
            end
            mag = mag / x;
            d = d / x;
            // Negative results may reach one step further than positive ones.
            if ((n < 0 ? mag > 64'h8000_0000 : mag > 64'h7fff_ffff) || d > 64'h7fff_ffff) begin
               r.ovf = 1'b1;
            end else begin
               r.num = (n < 0) ? NUM_W'(-mag) : NUM_W'(mag);
               r.den = DEN_W'(d);
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH at cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_item(logic cmd, logic [NUM_W-1:0] an, logic [DEN_W-1:0] ad,
                             logic [NUM_W-1:0] bn, logic [DEN_W-1:0] bd, int gap,
                             bit drain = 0);
      rat_item_type it;
      it.cmd = cmd;
      it.a_num = an;
      it.a_den = ad;
      it.b_num = bn;
      it.b_den = bd;
      it.gap = gap;
      it.drain = drain;
      pending_items.push_back(it);
   endtask

   function automatic logic [NUM_W-1:0] rand_num();
      case ($urandom_range(0, 5))
         0: return NUM_W'($signed($urandom_range(0, 40)) - 20);
         1: return {1'b1, 31'h0} + NUM_W'($urandom_range(0, 3));
         2: return {1'b0, {31{1'b1}}} - NUM_W'($urandom_range(0, 3));
         3: return NUM_W'($signed($urandom_range(0, 20000)) - 10000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DEN_W-1:0] rand_den();
      case ($urandom_range(0, 7))
         0: return DEN_W'($urandom_range(1, 12));
         1: return {DEN_W{1'b1}} - DEN_W'($urandom_range(0, 2));
         2: return DEN_W'($urandom_range(1, 5000));
         3: return ($urandom_range(0, 7) == 0) ? '0 : DEN_W'($urandom_range(1, 3));
         4: return DEN_W'(1) << $urandom_range(0, 30);
         default: return DEN_W'($urandom);
      endcase
   endfunction

   // Driver: a new item goes out only once the previous transfer has happened.
   always @(posedge clock) begin
      rat_item_type it;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            it.cmd = req_cmd;
            it.a_num = req_a_num;
            it.a_den = req_a_den;
            it.b_num = req_b_num;
            it.b_den = req_b_den;
            expected_sums.push_back(add_sub_reduce(it));
         end
         if (!req_valid || !req_stall) begin
            if (wait_cnt != 0) begin
               req_valid <= 1'b0;
               wait_cnt <= wait_cnt - 1;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain && expected_sums.size() > 0)) begin
               it = pending_items.pop_front();
               req_cmd <= it.cmd;
               req_a_num <= it.a_num;
               req_a_den <= it.a_den;
               req_b_num <= it.b_num;
               req_b_den <= it.b_den;
               req_valid <= 1'b1;
               wait_cnt <= it.gap;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer and draws the stall before the next one.
   always @(posedge clock) begin
      rat_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               report_mismatch("unexpected result", rsp_res_num, 0);
            end else begin
               want = expected_sums.pop_front();
               result_count++;
               if (want.ovf) overflow_count++;
               if (!want.ovf && want.num == 0) zero_count++;
               if (rsp_res_num !== want.num) report_mismatch("res_num", rsp_res_num, want.num);
               if (rsp_res_den !== want.den) report_mismatch("res_den", rsp_res_den, want.den);
               if (rsp_operands_equal !== want.eq)
                  report_mismatch("operands_equal", rsp_operands_equal, want.eq);
               if (rsp_overflow !== want.ovf)
                  report_mismatch("overflow", rsp_overflow, want.ovf);
            end
            stall_cnt <= $urandom_range(0, stall_max);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= (stall_cnt != 0);
            if (stall_cnt != 0) stall_cnt <= stall_cnt - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 3000000) begin
         $display("Timeout with %0d results outstanding", expected_sums.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [NUM_W-1:0] n_min, n_max, v;
      logic [DEN_W-1:0] d_max;
      int gap_max;
      n_min = {1'b1, 31'h0};
      n_max = {1'b0, {31{1'b1}}};
      d_max = {DEN_W{1'b1}};
      queue_item(CMD_ADD, n_min, 1, n_min, 1, 0);
      queue_item(CMD_SUB, n_min, 1, n_max, 1, 0);
      queue_item(CMD_ADD, n_max, 1, n_max, 1, 0);
      queue_item(CMD_SUB, n_max, 1, n_max, 1, 3);
      queue_item(CMD_SUB, 5, 7, 5, 7, 0);
      queue_item(CMD_ADD, 0, d_max, 0, 1, 0);
      queue_item(CMD_ADD, 3, 0, 4, 5, 0);
      queue_item(CMD_SUB, 3, 5, 4, 0, 2);
      queue_item(CMD_ADD, 0, 0, 0, 0, 0);
      queue_item(CMD_ADD, 1, d_max, 1, d_max, 0);
      queue_item(CMD_ADD, 1, d_max, 1, d_max - 1, 0);
      queue_item(CMD_SUB, n_min, d_max, n_max, d_max, 0);
      queue_item(CMD_ADD, n_max, d_max, n_min, 1, 5);
      queue_item(CMD_ADD, 1, 2, 1, 2, 0);
      queue_item(CMD_SUB, -1, 3, 1, 6, 0);
      queue_item(CMD_ADD, 32'hffff_ffff, 1, 1, 1, 0);
      queue_item(CMD_SUB, 32'h4000_0000, 2, 32'hc000_0000, 2, 0);
      queue_item(CMD_ADD, 32'haaaa_aaaa, 31'h5555_5555, 32'h5555_5555, 31'h2aaa_aaaa, 0);
      queue_item(CMD_SUB, 6, 4, 10, 8, 12, 1);
      queue_item(CMD_ADD, 7, 3, -7, 3, 0);
      gap_max = 12;
      for (int i = 0; i < 1130; i++) begin
         // Every 60 items, each side picks at random between no gaps and random gaps.
         if (i % 60 == 0) begin
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
            stall_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
         end
         v = rand_num();
         queue_item(1'($urandom_range(0, 1)), v, rand_den(),
                    ($urandom_range(0, 9) == 0) ? v : rand_num(), rand_den(),
                    $urandom_range(0, gap_max), (i % 250 == 100));
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !req_valid && expected_sums.size() == 0);
      repeat (400) @(posedge clock);
      $display("Checked %0d results: %0d with overflow, %0d reduced to zero.",
               result_count, overflow_count, zero_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatching fields", mismatch_count);
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire
